// ===== rtl/sta_pkg.sv =====
package sta_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int TIME_BITS    = 32;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_DEL   = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_SWEEP = 3'd3;
    localparam logic [2:0] MODE_COUNT = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot_index;
        logic [31:0] entry_payload;
        logic [31:0] entry_time;
        logic [31:0] age_limit;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic [3:0]  placed_slot;
        logic        read_valid;
        logic [31:0] read_payload;
        logic [31:0] read_time;
        logic [4:0]  valid_count;
    } t_out_beat;

    typedef logic [TABLE_DEPTH-1:0] t_valid;

    // add writes payload/time and sets the valid mark at wr_idx; clr drops it
    typedef struct packed {
        logic                    add;
        logic                    clr;
        logic [IDX_W-1:0]        wr_idx;
        logic [IDX_W-1:0]        rd_idx;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [TIME_BITS-1:0]    ts;
    } t_st_cmd;

    typedef struct packed {
        logic                    valid;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [TIME_BITS-1:0]    ts;
    } t_st_rd;

endpackage

// ===== rtl/slot_table_with_age_out_core.sv =====
// Table of TABLE_DEPTH client entries (valid mark, payload, last-contact time)
// with a running count of valid entries. One beat is worked at a time; the
// input stalls from acceptance until its result is moved to the output
// register, which can hold a finished result while the next beat is taken.
// A single scan index walks the table and one timestamp comparator serves the
// age-out sweep; the entry memory has a registered read port. An add scans
// from slot 0 for the lowest free slot; a read of an index beyond the table
// skips the memory read; the age-out sweep visits every slot with a memory
// read state and then a compare state. A finished result waits for the output
// register only while that register is full and stalled.
module slot_table_with_age_out_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sta_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sta_pkg::t_out_beat o_out_data
);

    sta_pkg::t_st_cmd   st_cmd;
    sta_pkg::t_valid    st_valid;
    sta_pkg::t_st_rd    st_rd;
    sta_pkg::t_out_beat res;
    logic               done;
    logic               out_free;
    logic               r_out_valid;
    sta_pkg::t_out_beat r_out;

    assign out_free = !r_out_valid || !i_out_stall;

    sta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res),
        .o_cmd      (st_cmd),
        .i_valid    (st_valid),
        .i_rd       (st_rd)
    );

    sta_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (st_cmd),
        .o_valid (st_valid),
        .o_rd    (st_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/sta_store.sv =====
module sta_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sta_pkg::t_st_cmd i_cmd,
    output sta_pkg::t_valid  o_valid,
    output sta_pkg::t_st_rd  o_rd
);

    logic [sta_pkg::PAYLOAD_BITS-1:0] r_pay_mem [sta_pkg::TABLE_DEPTH];
    logic [sta_pkg::TIME_BITS-1:0]    r_ts_mem  [sta_pkg::TABLE_DEPTH];
    logic [sta_pkg::PAYLOAD_BITS-1:0] r_rd_pay;
    logic [sta_pkg::TIME_BITS-1:0]    r_rd_ts;
    sta_pkg::t_valid                  r_valid;
    sta_pkg::t_valid                  r_written;
    logic                             r_rd_valid;
    logic                             r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_pay_mem[i_cmd.wr_idx] <= i_cmd.payload;
            r_ts_mem[i_cmd.wr_idx]  <= i_cmd.ts;
        end
        r_rd_pay <= r_pay_mem[i_cmd.rd_idx];
        r_rd_ts  <= r_ts_mem[i_cmd.rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_written    <= '0;
            r_rd_valid   <= 1'b0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_valid[i_cmd.wr_idx]   <= 1'b1;
                r_written[i_cmd.wr_idx] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid[i_cmd.wr_idx] <= 1'b0;
            end
            r_rd_valid   <= r_valid[i_cmd.rd_idx];
            r_rd_written <= r_written[i_cmd.rd_idx];
        end
    end

    // never-written entries read as zero
    assign o_valid       = r_valid;
    assign o_rd.valid    = r_rd_valid;
    assign o_rd.payload  = r_rd_written ? r_rd_pay : '0;
    assign o_rd.ts       = r_rd_written ? r_rd_ts : '0;

endmodule

// ===== rtl/sta_ctrl.sv =====
module sta_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sta_pkg::t_in_beat  i_in_data,
    input  logic               i_out_free,
    output logic               o_done,
    output sta_pkg::t_out_beat o_res,
    output sta_pkg::t_st_cmd   o_cmd,
    input  sta_pkg::t_valid    i_valid,
    input  sta_pkg::t_st_rd    i_rd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD_SCAN = 3'd1;
    localparam logic [2:0] ST_DEL      = 3'd2;
    localparam logic [2:0] ST_RD_ISSUE = 3'd3;
    localparam logic [2:0] ST_RD_CAP   = 3'd4;
    localparam logic [2:0] ST_SWP_RD   = 3'd5;
    localparam logic [2:0] ST_SWP_CMP  = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    localparam logic [sta_pkg::IDX_W-1:0] LAST_IDX =
        sta_pkg::IDX_W'(sta_pkg::TABLE_DEPTH - 1);
    localparam logic [sta_pkg::CNT_W-1:0] FULL_CNT =
        sta_pkg::CNT_W'(sta_pkg::TABLE_DEPTH);

    logic [2:0]                  r_state, n_state;
    logic [sta_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [sta_pkg::CNT_W-1:0]   r_count, n_count;
    sta_pkg::t_in_beat           r_beat, n_beat;
    sta_pkg::t_out_beat          r_res, n_res;
    logic [sta_pkg::IDX_W-1:0]   slot;
    logic                        slot_ok;
    logic                        older;

    assign slot    = sta_pkg::IDX_W'(r_beat.slot_index);
    assign slot_ok = (32'(r_beat.slot_index) < sta_pkg::TABLE_DEPTH);
    // the shared compare: stored timestamp against the sweep limit
    assign older   = i_valid[r_idx] &&
                     (i_rd.ts < sta_pkg::TIME_BITS'(r_beat.age_limit));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_beat      = r_beat;
        n_res       = r_res;
        o_cmd         = '0;
        o_cmd.wr_idx  = r_idx;
        o_cmd.rd_idx  = r_idx;
        o_cmd.payload = sta_pkg::PAYLOAD_BITS'(r_beat.entry_payload);
        o_cmd.ts      = sta_pkg::TIME_BITS'(r_beat.entry_time);
        o_in_stall  = (r_state != ST_IDLE);
        o_done      = (r_state == ST_DONE);
        o_res             = r_res;
        o_res.valid_count = 5'(r_count);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_beat = i_in_data;
                    n_res  = '0;
                    n_idx  = '0;
                    unique case (i_in_data.mode)
                        sta_pkg::MODE_ADD: begin
                            if (r_count >= FULL_CNT) begin
                                n_res.status = 1'b1;
                                n_state      = ST_DONE;
                            end else begin
                                n_state = ST_ADD_SCAN;
                            end
                        end
                        sta_pkg::MODE_DEL:   n_state = ST_DEL;
                        sta_pkg::MODE_READ:  n_state = ST_RD_ISSUE;
                        sta_pkg::MODE_SWEEP: n_state = ST_SWP_RD;
                        sta_pkg::MODE_COUNT: n_state = ST_DONE;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (!i_valid[r_idx]) begin
                    o_cmd.add         = 1'b1;
                    n_count           = r_count + 1'b1;
                    n_res.placed_slot = 4'(r_idx);
                    n_state           = ST_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_res.status = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DEL: begin
                o_cmd.wr_idx = slot;
                if (slot_ok && i_valid[slot]) begin
                    o_cmd.clr = 1'b1;
                    n_count   = r_count - 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_RD_ISSUE: begin
                o_cmd.rd_idx = slot;
                n_state      = slot_ok ? ST_RD_CAP : ST_DONE;
            end
            ST_RD_CAP: begin
                n_res.read_valid   = i_rd.valid;
                n_res.read_payload = 32'(i_rd.payload);
                n_res.read_time    = 32'(i_rd.ts);
                n_state            = ST_DONE;
            end
            ST_SWP_RD: begin
                n_state = ST_SWP_CMP;
            end
            ST_SWP_CMP: begin
                if (older) begin
                    o_cmd.clr = 1'b1;
                    n_count   = r_count - 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SWP_RD;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
        r_res  <= n_res;
    end

endmodule

// ===== rtl/sta_chk.sv =====
module sta_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sta_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sta_pkg::t_out_beat o_out_data
);

    // held beat must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    // one beat in flight: acceptance closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after acceptance");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.valid_count) <= sta_pkg::TABLE_DEPTH)
        else $error("valid count beyond table depth");

    // a full report means the table really is full and nothing was placed
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |->
            o_out_data.placed_slot == 4'd0 &&
            32'(o_out_data.valid_count) == sta_pkg::TABLE_DEPTH)
        else $error("full status with free slots");

endmodule

bind slot_table_with_age_out_core sta_chk u_sta_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== bench/tb.sv =====
module tb;
    import sta_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 5;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 2 * TABLE_DEPTH + 16;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_OPS       = 450;
    localparam int CHUNK_OPS        = 50;
    localparam int LONG_HOLD_CYCLES = 200;

    localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;
    localparam logic        STATUS_OK        = 1'b0;
    localparam logic        STATUS_FULL      = 1'b1;
    localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b1;
    t_out_beat out_beat;

    // table shadow
    logic                    tbl_valid   [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] tbl_payload [TABLE_DEPTH];
    logic [TIME_BITS-1:0]    tbl_time    [TABLE_DEPTH];
    logic [CNT_W-1:0]        tbl_count;

    t_out_beat   expected_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned ops_sent       = 0;
    int unsigned tx_gap_max     = 0;
    int unsigned rx_gap_max     = 0;
    int unsigned hold_requests  = 0;

    slot_table_with_age_out_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("slot_table_with_age_out_core verification failed");
        $finish;
    end

    function automatic void clear_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_payload[i] = '0;
            tbl_time[i]    = '0;
        end
        tbl_count = '0;
    endfunction

    function automatic t_out_beat apply_table_op(input t_in_beat op);
        t_out_beat res;
        logic      placed;
        int        i;
        res    = '0;
        placed = 1'b0;
        case (op.mode)
            MODE_ADD: begin
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (!placed && !tbl_valid[i]) begin
                        placed         = 1'b1;
                        tbl_valid[i]   = 1'b1;
                        tbl_payload[i] = op.entry_payload;
                        tbl_time[i]    = op.entry_time;
                        tbl_count++;
                        res.placed_slot = i[3:0];
                    end
                end
                res.status = placed ? STATUS_OK : STATUS_FULL;
            end
            MODE_DEL: begin
                if (tbl_valid[op.slot_index]) begin
                    tbl_valid[op.slot_index] = 1'b0;
                    tbl_count--;
                end
            end
            MODE_READ: begin
                res.read_valid   = tbl_valid[op.slot_index];
                res.read_payload = tbl_payload[op.slot_index];
                res.read_time    = tbl_time[op.slot_index];
            end
            MODE_SWEEP: begin
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_time[i] < op.age_limit) begin
                        tbl_valid[i] = 1'b0;
                        tbl_count--;
                    end
                end
            end
            default: ;
        endcase
        res.valid_count = tbl_count;
        return res;
    endfunction

    function automatic t_in_beat make_op(input logic [2:0] mode, input logic [3:0] slot,
                                         input logic [31:0] payload,
                                         input logic [31:0] stamp,
                                         input logic [31:0] limit);
        t_in_beat op;
        op.mode          = mode;
        op.slot_index    = slot;
        op.entry_payload = payload;
        op.entry_time    = stamp;
        op.age_limit     = limit;
        return op;
    endfunction

    function automatic logic [3:0] pick_live_slot();
        int live [$];
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i]) live.push_back(i);
        if (live.size() == 0) return 4'($urandom_range(TABLE_DEPTH - 1, 0));
        return 4'(live[$urandom_range(live.size() - 1, 0)]);
    endfunction

    function automatic logic [31:0] random_stamp();
        if ($urandom_range(1, 0) == 1) return $urandom();
        return $urandom_range(1023, 0);
    endfunction

    function automatic int unsigned pick_gap_limit();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 4;
            default: return 12;
        endcase
    endfunction

    // adds are weighted by add_pct; sweep limits often land on a live timestamp
    function automatic t_in_beat random_op(input int unsigned add_pct);
        t_in_beat    op;
        int unsigned pick;
        op = make_op(MODE_ADD, 4'($urandom_range(TABLE_DEPTH - 1, 0)), $urandom(),
                     random_stamp(), $urandom());
        if ($urandom_range(99, 0) < add_pct) return op;
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            op.mode = MODE_DEL;
            if ($urandom_range(4, 0) != 0) op.slot_index = pick_live_slot();
        end else if (pick < 65) begin
            op.mode = MODE_READ;
            if ($urandom_range(1, 0) == 1) op.slot_index = pick_live_slot();
        end else if (pick < 80) begin
            op.mode = MODE_SWEEP;
            case ($urandom_range(3, 0))
                0: op.age_limit = $urandom();
                1, 2: op.age_limit = tbl_time[pick_live_slot()] + $urandom_range(1, 0);
                default: op.age_limit = $urandom_range(1023, 0);
            endcase
        end else if (pick < 94) begin
            op.mode = MODE_COUNT;
        end else begin
            op.mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        end
        return op;
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input t_in_beat op);
        int unsigned gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= op;
        do @(posedge clk); while (in_stall !== 1'b0);
        expected_q.push_back(apply_table_op(op));
        if (op.mode < MODE_SPARE_FIRST) ops_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_table();
        logic [2:0] mode;
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_beat(make_op(MODE_COUNT, 4'd0, $urandom(), $urandom(), $urandom()));
        send_beat(make_op(MODE_READ, 4'd0, $urandom(), $urandom(), $urandom()));
        send_beat(make_op(MODE_DEL, 4'd5, $urandom(), $urandom(), $urandom()));
        for (mode = MODE_SPARE_FIRST; mode != MODE_ADD; mode++)
            send_beat(make_op(mode, 4'($urandom()), $urandom(), $urandom(), $urandom()));
    endtask

    task automatic test_fill_to_full();
        logic [31:0] stamp;
        int          i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            stamp = (i % 4 == 0) ? ALL_ONES : 32'(i - 1);
            send_beat(make_op(MODE_ADD, 4'($urandom()), (i % 2 == 1) ? ALL_ONES : '0,
                              stamp, $urandom()));
        end
        send_beat(make_op(MODE_ADD, 4'($urandom()), ALL_ONES, ALL_ONES, $urandom()));
    endtask

    // boundary: an entry whose time equals the limit survives
    task automatic test_sweep_extremes();
        send_beat(make_op(MODE_SWEEP, 4'($urandom()), $urandom(), $urandom(), '0));
        send_beat(make_op(MODE_SWEEP, 4'($urandom()), $urandom(), $urandom(), 32'd5));
        send_beat(make_op(MODE_READ, 4'd1, $urandom(), $urandom(), $urandom()));
        send_beat(make_op(MODE_SWEEP, 4'($urandom()), $urandom(), $urandom(), ALL_ONES));
        send_beat(make_op(MODE_DEL, 4'd4, $urandom(), $urandom(), $urandom()));
    endtask

    task automatic test_random_traffic();
        int unsigned start_ops;
        int unsigned add_pct;
        int          n;
        start_ops = ops_sent;
        while (ops_sent - start_ops < RANDOM_OPS) begin
            tx_gap_max = pick_gap_limit();
            rx_gap_max = pick_gap_limit();
            add_pct    = $urandom_range(70, 25);
            for (n = 0; n < CHUNK_OPS; n++) send_beat(random_op(add_pct));
        end
    endtask

    task automatic test_output_backpressure();
        int n;
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_requests++;
        for (n = 0; n < 12; n++) send_beat(random_op(50));
        wait_drained();
    endtask

    task automatic test_sender_pause();
        int n;
        int burst;
        tx_gap_max = 0;
        rx_gap_max = 2;
        for (burst = 0; burst < 2; burst++) begin
            for (n = 0; n < 8; n++) send_beat(random_op(40));
            wait_drained();
        end
    endtask

    // output side: random stall per beat, plus long holds on request
    initial begin
        int unsigned holds_served;
        int unsigned wait_cycles;
        holds_served = 0;
        @(negedge clk);
        forever begin
            wait_cycles = $urandom_range(rx_gap_max, 0);
            if (hold_requests != holds_served) begin
                wait_cycles = LONG_HOLD_CYCLES;
                holds_served++;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: %p", out_beat);
            end else begin
                want = expected_q.pop_front();
                if (out_beat.status !== want.status
                        || out_beat.placed_slot !== want.placed_slot
                        || out_beat.read_valid !== want.read_valid
                        || out_beat.read_payload !== want.read_payload
                        || out_beat.read_time !== want.read_time
                        || out_beat.valid_count !== want.valid_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch exp: st=%0d slot=%0d rv=%0d pay=%h t=%h cnt=%0d",
                                 want.status, want.placed_slot, want.read_valid,
                                 want.read_payload, want.read_time, want.valid_count);
                        $display("         got: st=%0d slot=%0d rv=%0d pay=%h t=%h cnt=%0d",
                                 out_beat.status, out_beat.placed_slot,
                                 out_beat.read_valid, out_beat.read_payload,
                                 out_beat.read_time, out_beat.valid_count);
                    end
                end
            end
        end
    end

    initial begin
        clear_table();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_table();
        test_fill_to_full();
        test_sweep_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("slot_table_with_age_out_core verification clean");
        end else begin
            $display("slot_table_with_age_out_core verification failed");
        end
        $finish;
    end

endmodule

// ===== slot_table_with_age_out_core.f =====
rtl/sta_pkg.sv
rtl/sta_store.sv
rtl/sta_ctrl.sv
rtl/slot_table_with_age_out_core.sv
rtl/sta_chk.sv
bench/tb.sv
